>>> rtl/hwt_pkg.sv
// Shared types and constants of the hierarchical timer wheel.
`timescale 1ns / 1ps
package hwt_pkg;

  // Link field width; the all-ones code marks an empty link
  localparam int LW = 6;
  localparam logic [LW-1:0] NIL = 6'd63;

  // Farthest look-ahead of a query on an empty wheel
  localparam logic [31:0] MAX_AHEAD = 32'h3fff_ffff;

  // Operation codes
  localparam logic [1:0] FN_ADD   = 2'd0;
  localparam logic [1:0] FN_DEL   = 2'd1;
  localparam logic [1:0] FN_RUN   = 2'd2;
  localparam logic [1:0] FN_QUERY = 2'd3;

  // Result kinds
  localparam logic [1:0] KD_ACK   = 2'd0;
  localparam logic [1:0] KD_EXP   = 2'd1;
  localparam logic [1:0] KD_COUNT = 2'd2;
  localparam logic [1:0] KD_NEXT  = 2'd3;

  // Shared adder operations
  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  timer_id;
    logic [31:0] expiry;
    logic [31:0] target_time;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  expired_id;
    logic [31:0] value;
    logic        last;
  } out_t;

endpackage

>>> rtl/hwt_alu.sv
// Shared 32-bit add/subtract unit of the timer wheel sequencer.
`timescale 1ns / 1ps
module hwt_alu import hwt_pkg::*; (
  input  logic        op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  // Add or subtract; compares read the sign of the difference
  assign y = (op == ALU_SUB) ? (a - b) : (a + b);

endmodule

>>> rtl/hwt_bucket_mem.sv
// Bucket head and tail memory with one write and one registered read port.
`timescale 1ns / 1ps
module hwt_bucket_mem import hwt_pkg::*; #(
  parameter int DEPTH = 512,
  parameter int AW = 9
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [LW-1:0] head_q,
  output logic [LW-1:0] tail_q,
  input  logic [AW-1:0] wr_addr,
  input  logic          we_head,
  input  logic          we_tail,
  input  logic [LW-1:0] wr_head,
  input  logic [LW-1:0] wr_tail
);

  logic [LW-1:0] head_mem [DEPTH];
  logic [LW-1:0] tail_mem [DEPTH];

  // Write either half of a bucket
  always_ff @(posedge clk) begin
    if (we_head) begin
      head_mem[wr_addr] <= wr_head;
    end
    if (we_tail) begin
      tail_mem[wr_addr] <= wr_tail;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    head_q <= head_mem[rd_addr];
    tail_q <= tail_mem[rd_addr];
  end

endmodule

>>> rtl/hwt_out_reg.sv
// Output holding register between the sequencer and the result channel.
`timescale 1ns / 1ps
module hwt_out_reg import hwt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  out_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  assign in_ready = !out_valid || out_ready;

  // Hold the word until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= in_data;
    end
  end

endmodule

>>> rtl/hierarchical_timer_wheel_unit.sv
// Top level of the hierarchical timer wheel: sequencer, timer table and wiring.
//
// Usage: in_data carries one operation word (add/modify, delete, run, query),
// taken when in_valid and in_ready are both high. in_ready is high only while
// the sequencer is idle; each word runs to completion before the next.
// Results leave on out_data under valid/ready, one word per expired timer
// and one closing word with last set. A stalled receiver holds the sequencer
// at its next result; one finished word waits in the output register.
// Add/modify and delete answer with one acknowledge word; in_ready returns
// once that word is passed to the output register. A query scans the near
// buckets, then the coarse buckets, walking the timers of each one it reads.
// A run visits tick by tick (empty ticks are skipped up to the next near
// revolution at once when the near wheel is empty), expires the timers of
// each tick, and cascades coarse buckets, refiling their timers. All of it
// goes through one shared 32-bit adder and the one read and one write port
// of the bucket memory.
// Reset, and every write of cfg_data (the start time), empties the wheel:
// a clearing pass writes all NBUCKETS buckets (512 by default)
// while in_ready stays low.
`timescale 1ns / 1ps
module hierarchical_timer_wheel_unit import hwt_pkg::*; #(
  parameter int NEAR_BITS = 8,
  parameter int FAR_BITS = 6,
  parameter int POOL_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);

  localparam int NEAR_SIZE = 1 << NEAR_BITS;
  localparam int FAR_SIZE = 1 << FAR_BITS;
  localparam int NBUCKETS = NEAR_SIZE + 4 * FAR_SIZE;
  localparam int BW = $clog2(NBUCKETS);
  localparam int PW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CW = $clog2(POOL_SIZE + 1);
  localparam int SW = (NEAR_BITS > FAR_BITS) ? NEAR_BITS : FAR_BITS;
  localparam int N = NEAR_BITS;
  localparam int F = FAR_BITS;

  localparam logic [BW-1:0] B_FAR0 = BW'(NEAR_SIZE);
  localparam logic [BW-1:0] B_LAST = BW'(NBUCKETS - 1);
  localparam logic [LW-1:0] POOL_L = LW'(POOL_SIZE);

  // Sequencer states
  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_TUNL  = 5'd2;
  localparam logic [4:0] S_LPICK = 5'd3;
  localparam logic [4:0] S_LWR   = 5'd4;
  localparam logic [4:0] S_ACK   = 5'd5;
  localparam logic [4:0] S_RCHK  = 5'd6;
  localparam logic [4:0] S_CRD   = 5'd7;
  localparam logic [4:0] S_CCLR  = 5'd8;
  localparam logic [4:0] S_CLOOP = 5'd9;
  localparam logic [4:0] S_RRD   = 5'd10;
  localparam logic [4:0] S_RHEAD = 5'd11;
  localparam logic [4:0] S_REXP  = 5'd12;
  localparam logic [4:0] S_RDONE = 5'd13;
  localparam logic [4:0] S_QINIT = 5'd14;
  localparam logic [4:0] S_QNRD  = 5'd15;
  localparam logic [4:0] S_QNHD  = 5'd16;
  localparam logic [4:0] S_QTJ   = 5'd17;
  localparam logic [4:0] S_QFRD  = 5'd18;
  localparam logic [4:0] S_QFHD  = 5'd19;
  localparam logic [4:0] S_QWALK = 5'd20;
  localparam logic [4:0] S_QOUT  = 5'd21;

  function automatic logic link_ok(input logic [LW-1:0] l);
    return l < POOL_L;
  endfunction

  // Control registers
  logic [4:0]    state, state_next;
  logic [BW-1:0] clr, clr_next;
  logic [31:0]   cur, cur_next;
  logic [CW-1:0] near_cnt, near_cnt_next;
  logic [CW-1:0] pend_cnt, pend_cnt_next;
  logic [POOL_SIZE-1:0] pending;

  // Working registers
  in_t           req, req_next;
  logic [LW-1:0] t, t_next;
  logic [LW-1:0] lt, lt_next;
  logic [BW-1:0] lb, lb_next;
  logic          ret_add, ret_add_next;
  logic [1:0]    clvl, clvl_next;
  logic [BW-1:0] cb, cb_next;
  logic          czero, czero_next;
  logic [31:0]   rem_q, rem_q_next;
  logic [CW-1:0] count, count_next;
  logic [31:0]   tj, tj_next;
  logic [31:0]   best, best_next;
  logic          found, found_next;
  logic [SW-1:0] qidx, qidx_next;
  logic [SW-1:0] qslot, qslot_next;
  logic          qnear, qnear_next;
  logic [1:0]    qlvl, qlvl_next;

  // Timer table
  logic [31:0]   ent_exp  [POOL_SIZE];
  logic [LW-1:0] ent_next [POOL_SIZE];
  logic [LW-1:0] ent_prev [POOL_SIZE];
  logic [BW-1:0] ent_bkt  [POOL_SIZE];

  logic [LW-1:0] eaddr;
  logic [31:0]   ee_exp;
  logic [LW-1:0] ee_next, ee_prev;
  logic [BW-1:0] ee_bkt;

  logic          exp_we;
  logic          nx0_we, nx1_we, pv_we, bk_we, pd_we, pd_d;
  logic [PW-1:0] nx0_a, nx1_a, pv_a, bk_a, pd_a;
  logic [LW-1:0] nx0_d, nx1_d, pv_d;
  logic [BW-1:0] bk_d;

  // Bucket memory port
  logic [BW-1:0] m_ra, m_wa;
  logic          m_we_h, m_we_t;
  logic [LW-1:0] m_wh, m_wt, head_q, tail_q;

  // Shared adder
  logic        alu_op;
  logic [31:0] alu_a, alu_b, alu_y;

  // Result word to the output register
  logic emit_valid, emit_ready;
  out_t emit_word;

  // Derived values
  logic [PW-1:0]  id_idx;
  logic           id_ok;
  logic [N-1:0]   idx;
  logic [BW-1:0]  idx_b;
  logic [N:0]     step;
  logic [F-1:0]   cslot;
  logic [BW-1:0]  casc_b;
  logic [BW-1:0]  pick_b;
  logic [N-1:0]   nsn;
  logic [F-1:0]   fsn;
  logic [BW-1:0]  qfar_b;
  logic [31:0]    tj_adj, tj_new;
  logic           q_wrap;

  assign id_idx = req.timer_id[PW-1:0];
  assign id_ok  = {1'b0, req.timer_id} < POOL_L;
  assign idx    = cur[N-1:0];
  assign idx_b  = BW'(idx);
  assign step   = (N + 1)'(NEAR_SIZE) - {1'b0, idx};
  assign nsn    = qslot[N-1:0] + 1'b1;
  assign fsn    = qslot[F-1:0] + 1'b1;
  assign qfar_b = B_FAR0 + (BW'(qlvl) << F) + BW'(qslot[F-1:0]);
  assign q_wrap = (qidx == '0) || (qslot < qidx);
  assign in_ready = (state == S_IDLE);

  // Slot of the coarse level being cascaded
  always_comb begin
    unique case (clvl)
      2'd0: cslot = cur[N+F-1:N];
      2'd1: cslot = cur[N+2*F-1:N+F];
      2'd2: cslot = cur[N+3*F-1:N+2*F];
      default: cslot = cur[N+4*F-1:N+3*F];
    endcase
  end
  assign casc_b = B_FAR0 + (BW'(clvl) << F) + BW'(cslot);

  // Bucket for a timer from its distance to the current tick
  always_comb begin
    priority if ((alu_y >> N) == '0) begin
      pick_b = BW'(ee_exp[N-1:0]);
    end else if ((alu_y >> (N + F)) == '0) begin
      pick_b = B_FAR0 + BW'(ee_exp[N+F-1:N]);
    end else if ((alu_y >> (N + 2 * F)) == '0) begin
      pick_b = BW'(NEAR_SIZE + FAR_SIZE) + BW'(ee_exp[N+2*F-1:N+F]);
    end else if ((alu_y >> (N + 3 * F)) == '0) begin
      pick_b = BW'(NEAR_SIZE + 2 * FAR_SIZE) + BW'(ee_exp[N+3*F-1:N+2*F]);
    end else if (alu_y[31]) begin
      pick_b = idx_b;
    end else begin
      pick_b = BW'(NEAR_SIZE + 3 * FAR_SIZE) + BW'(ee_exp[N+4*F-1:N+3*F]);
    end
  end

  // Round the query tick up to the next slot boundary
  always_comb begin
    if (qidx == '0) begin
      tj_adj = '0;
    end else if (qnear) begin
      tj_adj = 32'(NEAR_SIZE) - 32'(qidx[N-1:0]);
    end else begin
      tj_adj = 32'(FAR_SIZE) - 32'(qidx[F-1:0]);
    end
    tj_new = qnear ? (alu_y >> N) : (alu_y >> F);
  end

  // Select the timer table entry read this cycle
  always_comb begin
    unique case (state)
      S_TUNL:                    eaddr = LW'(req.timer_id);
      S_CLOOP, S_REXP, S_QWALK:  eaddr = t;
      S_QNHD:                    eaddr = head_q;
      default:                   eaddr = lt;
    endcase
  end
  assign ee_exp  = ent_exp[eaddr[PW-1:0]];
  assign ee_next = ent_next[eaddr[PW-1:0]];
  assign ee_prev = ent_prev[eaddr[PW-1:0]];
  assign ee_bkt  = ent_bkt[eaddr[PW-1:0]];

  // Operands of the shared adder
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = cur;
    alu_b  = '0;
    unique case (state)
      S_LPICK: begin
        alu_op = ALU_SUB;
        alu_a  = ee_exp;
        alu_b  = cur;
      end
      S_RCHK: begin
        alu_op = ALU_SUB;
        alu_a  = req.target_time;
        alu_b  = cur;
      end
      S_RHEAD: begin
        alu_b = 32'd1;
        if (!link_ok(head_q)) begin
          priority if (pend_cnt == '0) begin
            alu_a = req.target_time;
          end else if (near_cnt == '0) begin
            if (rem_q >= 32'(step)) begin
              alu_b = 32'(step);
            end else begin
              alu_a = req.target_time;
            end
          end else begin
            alu_a = cur;
          end
        end
      end
      S_QINIT: begin
        alu_b = MAX_AHEAD;
      end
      S_QTJ: begin
        alu_a = tj;
        alu_b = tj_adj;
      end
      S_QWALK: begin
        alu_op = ALU_SUB;
        alu_a  = ee_exp;
        alu_b  = best;
      end
      default: begin
        alu_a = cur;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_next    = state;
    clr_next      = clr;
    cur_next      = cur;
    near_cnt_next = near_cnt;
    pend_cnt_next = pend_cnt;
    req_next      = req;
    t_next        = t;
    lt_next       = lt;
    lb_next       = lb;
    ret_add_next  = ret_add;
    clvl_next     = clvl;
    cb_next       = cb;
    czero_next    = czero;
    rem_q_next    = rem_q;
    count_next    = count;
    tj_next       = tj;
    best_next     = best;
    found_next    = found;
    qidx_next     = qidx;
    qslot_next    = qslot;
    qnear_next    = qnear;
    qlvl_next     = qlvl;

    exp_we = 1'b0;
    nx0_we = 1'b0; nx0_a = '0; nx0_d = NIL;
    nx1_we = 1'b0; nx1_a = '0; nx1_d = NIL;
    pv_we  = 1'b0; pv_a  = '0; pv_d  = NIL;
    bk_we  = 1'b0; bk_a  = '0; bk_d  = '0;
    pd_we  = 1'b0; pd_a  = '0; pd_d  = 1'b0;

    m_ra   = '0;
    m_wa   = '0;
    m_we_h = 1'b0;
    m_we_t = 1'b0;
    m_wh   = NIL;
    m_wt   = NIL;

    emit_valid = 1'b0;
    emit_word  = '0;

    unique case (state)
      S_CLEAR: begin
        // Empty one bucket a cycle
        m_wa     = clr;
        m_we_h   = 1'b1;
        m_we_t   = 1'b1;
        clr_next = clr + 1'b1;
        if (clr == B_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_next   = in_data;
          count_next = '0;
          unique case (in_data.func)
            FN_RUN:   state_next = S_RCHK;
            FN_QUERY: state_next = S_QINIT;
            default:  state_next = S_TUNL;
          endcase
        end
      end
      S_TUNL: begin
        state_next = S_ACK;
        if (id_ok) begin
          // Unlink a pending timer from its bucket
          if (pending[id_idx]) begin
            m_wa = ee_bkt;
            if (link_ok(ee_prev)) begin
              nx0_we = 1'b1;
              nx0_a  = ee_prev[PW-1:0];
              nx0_d  = ee_next;
            end else begin
              m_we_h = 1'b1;
              m_wh   = ee_next;
            end
            if (link_ok(ee_next)) begin
              pv_we = 1'b1;
              pv_a  = ee_next[PW-1:0];
              pv_d  = ee_prev;
            end else begin
              m_we_t = 1'b1;
              m_wt   = ee_prev;
            end
            if (ee_bkt < B_FAR0 && near_cnt != '0) begin
              near_cnt_next = near_cnt - 1'b1;
            end
            pd_we = 1'b1;
            pd_a  = id_idx;
            pd_d  = 1'b0;
            if (pend_cnt != '0) begin
              pend_cnt_next = pend_cnt - 1'b1;
            end
          end
          if (req.func == FN_ADD) begin
            exp_we       = 1'b1;
            lt_next      = LW'(req.timer_id);
            ret_add_next = 1'b1;
            state_next   = S_LPICK;
          end
        end
      end
      S_LPICK: begin
        // Pick the bucket and fetch its tail
        m_ra       = pick_b;
        lb_next    = pick_b;
        state_next = S_LWR;
      end
      S_LWR: begin
        // Append at the tail of the bucket
        nx0_we = 1'b1;
        nx0_a  = lt[PW-1:0];
        nx0_d  = NIL;
        pv_we  = 1'b1;
        pv_a   = lt[PW-1:0];
        pv_d   = tail_q;
        bk_we  = 1'b1;
        bk_a   = lt[PW-1:0];
        bk_d   = lb;
        m_wa   = lb;
        m_we_t = 1'b1;
        m_wt   = lt;
        if (link_ok(tail_q)) begin
          nx1_we = 1'b1;
          nx1_a  = tail_q[PW-1:0];
          nx1_d  = lt;
        end else begin
          m_we_h = 1'b1;
          m_wh   = lt;
        end
        if (lb < B_FAR0) begin
          near_cnt_next = near_cnt + 1'b1;
        end
        if (ret_add) begin
          pd_we         = 1'b1;
          pd_a          = lt[PW-1:0];
          pd_d          = 1'b1;
          pend_cnt_next = pend_cnt + 1'b1;
          state_next    = S_ACK;
        end else begin
          state_next = S_CLOOP;
        end
      end
      S_ACK: begin
        emit_valid     = 1'b1;
        emit_word.kind = KD_ACK;
        emit_word.last = 1'b1;
        if (emit_ready) begin
          state_next = S_IDLE;
        end
      end
      S_RCHK: begin
        // Stop once the target lies behind the current tick
        rem_q_next = alu_y;
        priority if (alu_y[31]) begin
          state_next = S_RDONE;
        end else if (idx == '0) begin
          clvl_next  = 2'd0;
          state_next = S_CRD;
        end else begin
          state_next = S_RRD;
        end
      end
      S_CRD: begin
        m_ra       = casc_b;
        cb_next    = casc_b;
        czero_next = (cslot == '0);
        state_next = S_CCLR;
      end
      S_CCLR: begin
        // Detach the coarse bucket's list
        t_next     = head_q;
        m_wa       = cb;
        m_we_h     = 1'b1;
        m_we_t     = 1'b1;
        state_next = S_CLOOP;
      end
      S_CLOOP: begin
        // Refile each timer of the detached list
        priority if (link_ok(t)) begin
          lt_next      = t;
          t_next       = ee_next;
          ret_add_next = 1'b0;
          state_next   = S_LPICK;
        end else if (czero && clvl != 2'd3) begin
          clvl_next  = clvl + 1'b1;
          state_next = S_CRD;
        end else begin
          state_next = S_RRD;
        end
      end
      S_RRD: begin
        m_ra       = idx_b;
        state_next = S_RHEAD;
      end
      S_RHEAD: begin
        // Advance time: expire, finish, skip ahead (to the next revolution or past the target) or step one tick
        cur_next = alu_y;
        priority if (link_ok(head_q)) begin
          m_wa       = idx_b;
          m_we_h     = 1'b1;
          m_we_t     = 1'b1;
          t_next     = head_q;
          state_next = S_REXP;
        end else if (pend_cnt == '0) begin
          state_next = S_RDONE;
        end else begin
          state_next = S_RCHK;
        end
      end
      S_REXP: begin
        if (link_ok(t)) begin
          emit_valid           = 1'b1;
          emit_word.kind       = KD_EXP;
          emit_word.expired_id = t[4:0];
          if (emit_ready) begin
            pd_we = 1'b1;
            pd_a  = t[PW-1:0];
            pd_d  = 1'b0;
            if (near_cnt != '0) begin
              near_cnt_next = near_cnt - 1'b1;
            end
            if (pend_cnt != '0) begin
              pend_cnt_next = pend_cnt - 1'b1;
            end
            count_next = count + 1'b1;
            t_next     = ee_next;
          end
        end else begin
          state_next = S_RCHK;
        end
      end
      S_RDONE: begin
        emit_valid      = 1'b1;
        emit_word.kind  = KD_COUNT;
        emit_word.value = 32'(count);
        emit_word.last  = 1'b1;
        if (emit_ready) begin
          state_next = S_IDLE;
        end
      end
      S_QINIT: begin
        best_next  = alu_y;
        tj_next    = cur;
        qidx_next  = SW'(idx);
        qslot_next = SW'(idx);
        found_next = 1'b0;
        qnear_next = 1'b1;
        state_next = S_QNRD;
      end
      S_QNRD: begin
        m_ra       = BW'(qslot[N-1:0]);
        state_next = S_QNHD;
      end
      S_QNHD: begin
        // Scan the near wheel from the current slot
        priority if (link_ok(head_q)) begin
          found_next = 1'b1;
          best_next  = ee_exp;
          state_next = q_wrap ? S_QTJ : S_QOUT;
        end else if (nsn == qidx[N-1:0]) begin
          state_next = S_QTJ;
        end else begin
          qslot_next = SW'(nsn);
          state_next = S_QNRD;
        end
      end
      S_QTJ: begin
        // Move the query tick to the next level's slot
        tj_next    = tj_new;
        qidx_next  = SW'(tj_new[F-1:0]);
        qslot_next = SW'(tj_new[F-1:0]);
        priority if (qnear) begin
          qnear_next = 1'b0;
          qlvl_next  = 2'd0;
          state_next = S_QFRD;
        end else if (qlvl == 2'd3) begin
          state_next = S_QOUT;
        end else begin
          qlvl_next  = qlvl + 1'b1;
          state_next = S_QFRD;
        end
      end
      S_QFRD: begin
        m_ra       = qfar_b;
        state_next = S_QFHD;
      end
      S_QFHD: begin
        t_next     = head_q;
        state_next = S_QWALK;
      end
      S_QWALK: begin
        // Walk a coarse bucket, keep the earliest expiry
        priority if (link_ok(t)) begin
          found_next = 1'b1;
          if (alu_y[31]) begin
            best_next = ee_exp;
          end
          t_next = ee_next;
        end else if (found) begin
          state_next = q_wrap ? S_QTJ : S_QOUT;
        end else if (fsn == qidx[F-1:0]) begin
          state_next = S_QTJ;
        end else begin
          qslot_next = SW'(fsn);
          state_next = S_QFRD;
        end
      end
      S_QOUT: begin
        emit_valid      = 1'b1;
        emit_word.kind  = KD_NEXT;
        emit_word.value = best;
        emit_word.last  = 1'b1;
        if (emit_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state; a start time write restarts the wheel
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      cur      <= '0;
      near_cnt <= '0;
      pend_cnt <= '0;
    end else if (cfg_we) begin
      state    <= S_CLEAR;
      clr      <= '0;
      cur      <= cfg_data;
      near_cnt <= '0;
      pend_cnt <= '0;
    end else begin
      state    <= state_next;
      clr      <= clr_next;
      cur      <= cur_next;
      near_cnt <= near_cnt_next;
      pend_cnt <= pend_cnt_next;
    end
  end

  // Pending flags
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      pending <= '0;
    end else if (pd_we) begin
      pending[pd_a] <= pd_d;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    req     <= req_next;
    t       <= t_next;
    lt      <= lt_next;
    lb      <= lb_next;
    ret_add <= ret_add_next;
    clvl    <= clvl_next;
    cb      <= cb_next;
    czero   <= czero_next;
    rem_q   <= rem_q_next;
    count   <= count_next;
    tj      <= tj_next;
    best    <= best_next;
    found   <= found_next;
    qidx    <= qidx_next;
    qslot   <= qslot_next;
    qnear   <= qnear_next;
    qlvl    <= qlvl_next;
  end

  // Timer table writes
  always_ff @(posedge clk) begin
    if (exp_we) begin
      ent_exp[id_idx] <= req.expiry;
    end
    if (nx0_we) begin
      ent_next[nx0_a] <= nx0_d;
    end
    if (nx1_we) begin
      ent_next[nx1_a] <= nx1_d;
    end
    if (pv_we) begin
      ent_prev[pv_a] <= pv_d;
    end
    if (bk_we) begin
      ent_bkt[bk_a] <= bk_d;
    end
  end

  hwt_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  hwt_bucket_mem #(
    .DEPTH (NBUCKETS),
    .AW    (BW)
  ) u_bucket_mem (
    .clk     (clk),
    .rd_addr (m_ra),
    .head_q  (head_q),
    .tail_q  (tail_q),
    .wr_addr (m_wa),
    .we_head (m_we_h),
    .we_tail (m_we_t),
    .wr_head (m_wh),
    .wr_tail (m_wt)
  );

  hwt_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (emit_valid),
    .in_ready  (emit_ready),
    .in_data   (emit_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
